// File: design/swpi_pkg.sv
// package for the stack with positional insert
// holds command and status codes, field widths and the cell control struct
// no dependencies

package swpi_pkg;

    localparam int SWPI_DEPTH = 16;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // broadcast to every cell in the row
    typedef struct packed {
        logic                      shift_down;
        logic                      shift_up;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } cell_ctrl_t;

endpackage

// File: design/swpi_if.sv
// item channels of the stack with positional insert
// depends on swpi_pkg for field widths

interface swpi_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [swpi_pkg::FUNC_W-1:0]         func;
    logic signed [swpi_pkg::VALUE_W-1:0] value;
    logic [swpi_pkg::POS_W-1:0]          position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink   (input valid, input func, input value, input position, output ready);
endinterface

interface swpi_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [swpi_pkg::VALUE_W-1:0] read_value;
    logic [swpi_pkg::STATUS_W-1:0]       status;
    logic [swpi_pkg::LEVEL_W-1:0]        level;

    modport source (output valid, output read_value, output status, output level, input ready);
    modport sink   (input valid, input read_value, input status, input level, output ready);
endinterface

// File: design/swpi_cell.sv
// one storage cell of the stack row, cell 0 is the top of the stack
// depends on swpi_pkg for the control struct

module swpi_cell #(
    parameter int IDX = 0
) (
    input  logic                                clk,
    input  swpi_pkg::cell_ctrl_t                ctrl,
    input  logic signed [swpi_pkg::VALUE_W-1:0] up_data,
    input  logic signed [swpi_pkg::VALUE_W-1:0] down_data,
    output logic signed [swpi_pkg::VALUE_W-1:0] data
);
    import swpi_pkg::*;

    localparam int RB = $clog2(IDX + 2);
    localparam int RW = (RB > POS_W) ? RB + 1 : POS_W + 1;

    logic [RW-1:0]             rank;
    logic [RW-1:0]             pos_ext;
    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    assign rank    = RW'(IDX + 1);
    assign pos_ext = RW'(ctrl.position);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_down)
        begin
            // cells above the insert depth hold, the one at it loads, the rest move down
            if (rank == pos_ext)
            begin
                data_next = ctrl.value;
            end
            else if (rank > pos_ext)
            begin
                data_next = up_data;
            end
        end
        else if (ctrl.shift_up)
        begin
            data_next = down_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: design/stack_with_positional_insert.sv
// Bounded LIFO stack of signed 32-bit values with push, pop and insert at a
// depth counted from the top (1 is the top). The storage is a row of cells,
// cell 0 holding the top; every operation moves the whole row by at most one
// place, so one command item is taken per clock unless the response stalls.
// Each item gives one result item, registered in the cycle after acceptance;
// a command is taken whenever the result register is empty or its item is
// being taken in the same cycle. No clearing pass follows reset: slots are
// undefined until written and are never read beyond the fill count.
// depends on swpi_pkg, swpi_if and swpi_cell

module stack_with_positional_insert #(
    parameter int DEPTH = swpi_pkg::SWPI_DEPTH
) (
    input logic        clk,
    input logic        rst_n,
    swpi_cmd_if.sink   cmd,
    swpi_rsp_if.source rsp
);
    import swpi_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > POS_W) ? CW + 1 : POS_W + 1;
    localparam int LW = (CW > LEVEL_W) ? CW : LEVEL_W;

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] read_value_reg;
    logic signed [VALUE_W-1:0] read_value_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic [LEVEL_W-1:0]        level_reg;
    logic [LW-1:0]             level_wide;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic                      range_bad;
    logic                      do_ins;
    logic                      do_pop;
    logic [POS_W-1:0]          ins_pos;
    logic [EW-1:0]             pos_ext;
    logic [EW-1:0]             cnt_ext;
    cell_ctrl_t                ctrl;
    logic signed [VALUE_W-1:0] cell_data [DEPTH];

    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pos_ext   = EW'(cmd.position);
    assign cnt_ext   = EW'(count_reg);
    assign range_bad = (cmd.position == '0) || (pos_ext > cnt_ext + EW'(1));

    always_comb
    begin
        do_ins      = 1'b0;
        do_pop      = 1'b0;
        ins_pos     = POS_W'(1);
        status_next = ST_OK;
        unique case (cmd.func)
            FUNC_PUSH:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            FUNC_POP:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                    do_pop = 1'b1;
            end
            FUNC_INSERT:
            begin
                ins_pos = cmd.position;
                if (full)
                    status_next = ST_FULL;
                else if (range_bad)
                    status_next = ST_RANGE;
                else
                    do_ins = 1'b1;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign ctrl.shift_down = accept && do_ins;
    assign ctrl.shift_up   = accept && do_pop;
    assign ctrl.position   = ins_pos;
    assign ctrl.value      = cmd.value;

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + CW'(1);
        else if (do_pop)
            count_next = count_reg - CW'(1);
    end

    assign read_value_next = do_pop ? cell_data[0] : '0;
    assign level_wide      = LW'(count_next);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [VALUE_W-1:0] up_data;
            logic signed [VALUE_W-1:0] down_data;
            if (gi == 0)
            begin : g_top
                assign up_data = cmd.value;
            end
            else
            begin : g_mid_up
                assign up_data = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_bottom
                assign down_data = cell_data[gi];
            end
            else
            begin : g_mid_down
                assign down_data = cell_data[gi+1];
            end
            swpi_cell #(
                .IDX (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .up_data   (up_data),
                .down_data (down_data),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
            level_reg      <= level_wide[LEVEL_W-1:0];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.level      = level_reg;

    // fill count stays within the row
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    // a push on a stack with room grows it by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.func == FUNC_PUSH && !full |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow the stack");

    // a pop returns the old top cell
    a_pop_value: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.func == FUNC_POP && !empty |=> rsp.read_value == $past(cell_data[0]))
        else $error("pop returned the wrong value");

    // an empty refusal always reports a level of zero
    a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_EMPTY |-> rsp.level == '0)
        else $error("empty status with non-zero level");

endmodule
